[rtl/nlp_pkg.sv]
// ----------------------------------------------------------------------------
// nlp_pkg
// Shared types and constants for the next-permutation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package nlp_pkg;

  // Width of the count field and of every element index carried in the pipe
  localparam int unsigned CNT_W = 4;

  // Control word that travels down the pipe beside the elements
  typedef struct packed {
    logic             found;  // a pivot exists
    logic [CNT_W-1:0] cnt;    // saturated element count
    logic [CNT_W-1:0] piv;    // pivot position
    logic [CNT_W-1:0] succ;   // rightmost later element above the pivot
  } ctl_t;

endpackage

`default_nettype wire

[rtl/next_lexicographic_permutation.sv]
// ----------------------------------------------------------------------------
// next_lexicographic_permutation
// Next arrangement of a multiset in lexicographic order, four-stage pipeline.
// ----------------------------------------------------------------------------
// channel   dir  fields (tdata / tuser, lowest bit first)
// s_axis    in   tdata: count[3:0], elem_in_0 .. elem_in_{MAX_ELEMS-1}
// m_axis    out  tdata: elem_out_0 .. elem_out_{MAX_ELEMS-1}; tuser: advanced
//
// One beat per cycle sustained while m_axis is not stalled; a taken beat
// passes the scan, pivot, successor and build registers to the output.
// Reset clears only the stage valid bits; no clearing pass is needed.
// A stall on m_axis backs up stage by stage; each stage refills as soon as
// its successor moves, so no beat is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module next_lexicographic_permutation import nlp_pkg::*; #(
  parameter int unsigned MAX_ELEMS  = 10,
  parameter int unsigned ELEM_WIDTH = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // count, elem_in_0 .. elem_in_{MAX_ELEMS-1}
  input  wire logic [((CNT_W+MAX_ELEMS*ELEM_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // elem_out_0 .. elem_out_{MAX_ELEMS-1}
  output logic [((MAX_ELEMS*ELEM_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // advanced
  output logic                        m_axis_tuser
);

  logic [MAX_ELEMS-1:0][ELEM_WIDTH-1:0] elem_in, elem_s1, elem_s2, elem_s3, elem_out;
  logic [MAX_ELEMS-2:0]                 lt_s1;
  ctl_t                                 ctl_s1, ctl_s2, ctl_s3;
  logic                                 v1, v2, v3;
  logic                                 r2, r3, r4;

  always_comb begin
    for (int k = 0; k < MAX_ELEMS; k++) begin
      elem_in[k] = s_axis_tdata[CNT_W + k*ELEM_WIDTH +: ELEM_WIDTH];
    end
  end

  nlp_scan #(.MAX_ELEMS(MAX_ELEMS), .ELEM_WIDTH(ELEM_WIDTH)) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cnt_i      (s_axis_tdata[CNT_W-1:0]),
    .elem_i     (elem_in),
    .out_valid_o(v1),
    .out_ready_i(r2),
    .ctl_o      (ctl_s1),
    .lt_o       (lt_s1),
    .elem_o     (elem_s1)
  );

  nlp_pivot #(.MAX_ELEMS(MAX_ELEMS), .ELEM_WIDTH(ELEM_WIDTH)) u_pivot (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (v1),
    .in_ready_o (r2),
    .ctl_i      (ctl_s1),
    .lt_i       (lt_s1),
    .elem_i     (elem_s1),
    .out_valid_o(v2),
    .out_ready_i(r3),
    .ctl_o      (ctl_s2),
    .elem_o     (elem_s2)
  );

  nlp_succ #(.MAX_ELEMS(MAX_ELEMS), .ELEM_WIDTH(ELEM_WIDTH)) u_succ (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (v2),
    .in_ready_o (r3),
    .ctl_i      (ctl_s2),
    .elem_i     (elem_s2),
    .out_valid_o(v3),
    .out_ready_i(r4),
    .ctl_o      (ctl_s3),
    .elem_o     (elem_s3)
  );

  nlp_build #(.MAX_ELEMS(MAX_ELEMS), .ELEM_WIDTH(ELEM_WIDTH)) u_build (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (v3),
    .in_ready_o (r4),
    .ctl_i      (ctl_s3),
    .elem_i     (elem_s3),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .adv_o      (m_axis_tuser),
    .elem_o     (elem_out)
  );

  always_comb begin
    m_axis_tdata = '0;
    for (int k = 0; k < MAX_ELEMS; k++) begin
      m_axis_tdata[k*ELEM_WIDTH +: ELEM_WIDTH] = elem_out[k];
    end
  end

endmodule

`default_nettype wire

[rtl/nlp_scan.sv]
// ----------------------------------------------------------------------------
// nlp_scan
// Stage 1: saturate the count and compare every element with its successor.
// ----------------------------------------------------------------------------
`default_nettype none

module nlp_scan import nlp_pkg::*; #(
  parameter int unsigned MAX_ELEMS  = 10,
  parameter int unsigned ELEM_WIDTH = 8
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic [CNT_W-1:0]                      cnt_i,
  input  wire logic [MAX_ELEMS-1:0][ELEM_WIDTH-1:0]  elem_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output ctl_t                                       ctl_o,
  output logic [MAX_ELEMS-2:0]                       lt_o,
  output logic [MAX_ELEMS-1:0][ELEM_WIDTH-1:0]       elem_o
);

  logic                                 valid_q;
  logic [CNT_W-1:0]                     n_sat;
  logic [MAX_ELEMS-2:0]                 lt_d, lt_q;
  ctl_t                                 ctl_d, ctl_q;
  logic [MAX_ELEMS-1:0][ELEM_WIDTH-1:0] elem_q;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    n_sat = (cnt_i > CNT_W'(MAX_ELEMS)) ? CNT_W'(MAX_ELEMS) : cnt_i;
    for (int k = 0; k < MAX_ELEMS - 1; k++) begin
      lt_d[k] = ($signed(elem_i[k]) < $signed(elem_i[k+1])) &&
                (CNT_W'(k + 1) < n_sat);
    end
    ctl_d = '{found: 1'b0, cnt: n_sat, piv: '0, succ: '0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      lt_q   <= lt_d;
      ctl_q  <= ctl_d;
      elem_q <= elem_i;
    end
  end

  assign out_valid_o = valid_q;
  assign ctl_o       = ctl_q;
  assign lt_o        = lt_q;
  assign elem_o      = elem_q;

endmodule

`default_nettype wire

[rtl/nlp_pivot.sv]
// ----------------------------------------------------------------------------
// nlp_pivot
// Stage 2: locate the rightmost ascent, the pivot of the permutation.
// ----------------------------------------------------------------------------
`default_nettype none

module nlp_pivot import nlp_pkg::*; #(
  parameter int unsigned MAX_ELEMS  = 10,
  parameter int unsigned ELEM_WIDTH = 8
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire ctl_t                                  ctl_i,
  input  wire logic [MAX_ELEMS-2:0]                  lt_i,
  input  wire logic [MAX_ELEMS-1:0][ELEM_WIDTH-1:0]  elem_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output ctl_t                                       ctl_o,
  output logic [MAX_ELEMS-1:0][ELEM_WIDTH-1:0]       elem_o
);

  logic                                 valid_q;
  ctl_t                                 ctl_d, ctl_q;
  logic [MAX_ELEMS-1:0][ELEM_WIDTH-1:0] elem_q;

  assign in_ready_o = !valid_q || out_ready_i;

  // ascents beyond the count are already masked, so the highest one wins
  always_comb begin
    ctl_d       = ctl_i;
    ctl_d.found = 1'b0;
    ctl_d.piv   = '0;
    for (int k = 0; k < MAX_ELEMS - 1; k++) begin
      if (lt_i[k]) begin
        ctl_d.found = 1'b1;
        ctl_d.piv   = CNT_W'(k);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ctl_q  <= ctl_d;
      elem_q <= elem_i;
    end
  end

  assign out_valid_o = valid_q;
  assign ctl_o       = ctl_q;
  assign elem_o      = elem_q;

endmodule

`default_nettype wire

[rtl/nlp_succ.sv]
// ----------------------------------------------------------------------------
// nlp_succ
// Stage 3: find the rightmost element after the pivot that exceeds it.
// ----------------------------------------------------------------------------
`default_nettype none

module nlp_succ import nlp_pkg::*; #(
  parameter int unsigned MAX_ELEMS  = 10,
  parameter int unsigned ELEM_WIDTH = 8
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire ctl_t                                  ctl_i,
  input  wire logic [MAX_ELEMS-1:0][ELEM_WIDTH-1:0]  elem_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output ctl_t                                       ctl_o,
  output logic [MAX_ELEMS-1:0][ELEM_WIDTH-1:0]       elem_o
);

  logic                                 valid_q;
  logic [ELEM_WIDTH-1:0]                piv_val;
  ctl_t                                 ctl_d, ctl_q;
  logic [MAX_ELEMS-1:0][ELEM_WIDTH-1:0] elem_q;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    piv_val = elem_i[0];
    for (int j = 0; j < MAX_ELEMS; j++) begin
      if (CNT_W'(j) == ctl_i.piv) begin
        piv_val = elem_i[j];
      end
    end
    ctl_d      = ctl_i;
    ctl_d.succ = '0;
    for (int j = 0; j < MAX_ELEMS; j++) begin
      if (($signed(elem_i[j]) > $signed(piv_val)) &&
          (CNT_W'(j) > ctl_i.piv) && (CNT_W'(j) < ctl_i.cnt)) begin
        ctl_d.succ = CNT_W'(j);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ctl_q  <= ctl_d;
      elem_q <= elem_i;
    end
  end

  assign out_valid_o = valid_q;
  assign ctl_o       = ctl_q;
  assign elem_o      = elem_q;

endmodule

`default_nettype wire

[rtl/nlp_build.sv]
// ----------------------------------------------------------------------------
// nlp_build
// Stage 4: swap pivot and successor, reverse the tail, hold the result.
// ----------------------------------------------------------------------------
`default_nettype none

module nlp_build import nlp_pkg::*; #(
  parameter int unsigned MAX_ELEMS  = 10,
  parameter int unsigned ELEM_WIDTH = 8
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire ctl_t                                  ctl_i,
  input  wire logic [MAX_ELEMS-1:0][ELEM_WIDTH-1:0]  elem_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic                                       adv_o,
  output logic [MAX_ELEMS-1:0][ELEM_WIDTH-1:0]       elem_o
);

  logic                                 valid_q;
  logic                                 adv_q;
  logic [CNT_W:0]                       base;
  logic [CNT_W:0]                       src;
  logic [ELEM_WIDTH-1:0]                piv_val, succ_val, pick;
  logic [MAX_ELEMS-1:0][ELEM_WIDTH-1:0] elem_d, elem_q;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    piv_val  = elem_i[0];
    succ_val = elem_i[0];
    for (int j = 0; j < MAX_ELEMS; j++) begin
      if (CNT_W'(j) == ctl_i.piv)  piv_val  = elem_i[j];
      if (CNT_W'(j) == ctl_i.succ) succ_val = elem_i[j];
    end
    // tail position k reads from base - k; with no pivot the whole used part reverses
    base = ctl_i.found ? ({1'b0, ctl_i.cnt} + {1'b0, ctl_i.piv})
                       : ({1'b0, ctl_i.cnt} - (CNT_W+1)'(1));
    src  = '0;
    pick = elem_i[0];
    for (int k = 0; k < MAX_ELEMS; k++) begin
      src  = base - (CNT_W+1)'(k);
      pick = elem_i[k];
      for (int j = 0; j < MAX_ELEMS; j++) begin
        if ((CNT_W+1)'(j) == src) pick = elem_i[j];
      end
      if (CNT_W'(k) >= ctl_i.cnt) begin
        elem_d[k] = elem_i[k];
      end else if (ctl_i.found && (CNT_W'(k) < ctl_i.piv)) begin
        elem_d[k] = elem_i[k];
      end else if (ctl_i.found && (CNT_W'(k) == ctl_i.piv)) begin
        elem_d[k] = succ_val;
      end else if (ctl_i.found && (src == {1'b0, ctl_i.succ})) begin
        // the successor slot holds the old pivot after the swap
        elem_d[k] = piv_val;
      end else begin
        elem_d[k] = pick;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      adv_q  <= ctl_i.found;
      elem_q <= elem_d;
    end
  end

  assign out_valid_o = valid_q;
  assign adv_o       = adv_q;
  assign elem_o      = elem_q;

endmodule

`default_nettype wire

[rtl/nlp_checker.sv]
// ----------------------------------------------------------------------------
// nlp_checker
// Port-level checks for the next-permutation block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nlp_checker import nlp_pkg::*; #(
  parameter int unsigned MAX_ELEMS  = 10,
  parameter int unsigned ELEM_WIDTH = 8
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [((MAX_ELEMS*ELEM_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  input wire logic                   m_axis_tuser
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // an empty output stage means the whole pipe can take a beat
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input not ready with empty pipeline");

  // with the sink open, a taken beat passes the scan, pivot, successor and build registers to the output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready ##1 m_axis_tready ##1 m_axis_tready
      ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result missing after pipeline latency");

endmodule

bind next_lexicographic_permutation nlp_checker #(
  .MAX_ELEMS (MAX_ELEMS),
  .ELEM_WIDTH(ELEM_WIDTH)
) u_nlp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire

[bench/next_lexicographic_permutation_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// next_lexicographic_permutation_tb
// Self-checking bench for the next-permutation stream block.
// Directed arrangements cover short counts, sorted and reverse-sorted inputs,
// repeated values, extreme values and saturated counts. Random arrangements
// follow, many of them walks that feed each successor back in as the next
// input. Every accepted beat is predicted locally and compared field by
// field against the output stream, under bursty input and a varying
// stall pattern on the output.
// ----------------------------------------------------------------------------

module next_lexicographic_permutation_tb;
  import nlp_pkg::*;

  localparam int N_ELEMS    = 10;
  localparam int ELEM_W     = 8;
  localparam int S_W        = ((CNT_W + N_ELEMS * ELEM_W + 7) / 8) * 8;
  localparam int M_W        = ((N_ELEMS * ELEM_W + 7) / 8) * 8;
  localparam int IDLE_LIMIT = 4000;
  localparam int N_RANDOM   = 680;

  typedef logic signed [ELEM_W-1:0] elem_t;

  typedef struct {
    logic [CNT_W-1:0] count;
    elem_t            elem [N_ELEMS];
    bit               hold_for_drain;  // wait for an empty pipe before sending
  } arrangement_t;

  typedef struct {
    logic  advanced;
    elem_t elem [N_ELEMS];
  } successor_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           s_axis_tvalid = 1'b0;
  logic           s_axis_tready;
  // count, elem_in_0 .. elem_in_9
  logic [S_W-1:0] s_axis_tdata = '0;
  logic           m_axis_tvalid;
  logic           m_axis_tready = 1'b0;
  // elem_out_0 .. elem_out_9
  logic [M_W-1:0] m_axis_tdata;
  // advanced
  logic           m_axis_tuser;

  arrangement_t pending_arrangements [$];
  successor_t   successors_due [$];
  arrangement_t on_bus;
  successor_t   exp_succ;
  logic [S_W-1:0] beat_bits;
  elem_t        got_elem;
  int           mismatch_cnt = 0;
  int           burst_left = 0;
  int           gap_left = 0;
  int           stall_mode = 0;
  int           mode_cycles = 0;
  int           idle_cycles = 0;
  bit           send_now;
  bit           ready_now;

  next_lexicographic_permutation #(
    .MAX_ELEMS (N_ELEMS),
    .ELEM_WIDTH(ELEM_W)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Next arrangement in lexicographic order; wraps to ascending on the last one
  function automatic successor_t next_arrangement(input arrangement_t a);
    successor_t r;
    int    n;
    int    p;
    int    q;
    int    piv;
    int    lo;
    int    hi;
    elem_t t;
    n = (a.count > N_ELEMS) ? N_ELEMS : int'(a.count);
    r.elem = a.elem;
    r.advanced = 1'b0;
    piv = -1;
    if (n >= 2) begin
      for (p = n - 2; p >= 0; p--) begin
        if (piv < 0 && r.elem[p] < r.elem[p+1]) piv = p;
      end
      lo = 0;
      if (piv >= 0) begin
        q = n - 1;
        while (!(r.elem[piv] < r.elem[q])) q--;
        t = r.elem[piv];
        r.elem[piv] = r.elem[q];
        r.elem[q] = t;
        lo = piv + 1;
        r.advanced = 1'b1;
      end
      hi = n - 1;
      while (lo < hi) begin
        t = r.elem[lo];
        r.elem[lo] = r.elem[hi];
        r.elem[hi] = t;
        lo++;
        hi--;
      end
    end
    return r;
  endfunction

  function automatic arrangement_t from_list(input int cnt, input int vals [N_ELEMS]);
    arrangement_t a;
    a.count = cnt[CNT_W-1:0];
    a.hold_for_drain = 1'b0;
    for (int k = 0; k < N_ELEMS; k++) a.elem[k] = elem_t'(vals[k]);
    return a;
  endfunction

  // Small spread gives many repeated values
  function automatic arrangement_t random_arrangement(input int cnt, input int spread);
    arrangement_t a;
    int base;
    base = $urandom;
    a.count = cnt[CNT_W-1:0];
    a.hold_for_drain = 1'b0;
    for (int k = 0; k < N_ELEMS; k++) a.elem[k] = elem_t'(base + $urandom_range(0, spread));
    return a;
  endfunction

  // Stimulus
  initial begin
    arrangement_t a;
    successor_t   s;
    int           len;
    int           v;
    int           pick;

    pending_arrangements.push_back(random_arrangement(0, 255));
    pending_arrangements.push_back(random_arrangement(1, 255));
    pending_arrangements.push_back(from_list(2, '{-5, 7, 1, 2, 3, 4, 5, 6, 8, 9}));
    pending_arrangements.push_back(from_list(2, '{7, -5, 0, 0, 0, 0, 0, 0, 0, 0}));
    pending_arrangements.push_back(from_list(2, '{3, 3, 9, -9, 9, -9, 9, -9, 9, -9}));
    pending_arrangements.push_back(from_list(3, '{1, 2, 3, 0, 0, 0, 0, 0, 0, 0}));
    pending_arrangements.push_back(from_list(3, '{1, 3, 2, 0, 0, 0, 0, 0, 0, 0}));
    pending_arrangements.push_back(from_list(3, '{3, 2, 1, 5, 4, 3, 2, 1, 0, -1}));
    pending_arrangements.push_back(from_list(3, '{1, 1, 2, 0, 0, 0, 0, 0, 0, 0}));
    pending_arrangements.push_back(from_list(3, '{2, 1, 1, -1, -1, -1, 0, 0, 0, 0}));
    pending_arrangements.push_back(
      from_list(10, '{-128, -100, -50, -1, 0, 1, 50, 100, 126, 127}));
    pending_arrangements.push_back(
      from_list(10, '{127, 126, 100, 50, 1, 0, -1, -50, -100, -128}));
    pending_arrangements.push_back(
      from_list(10, '{-128, -128, -128, -128, -128, -128, -128, -128, -128, -128}));
    pending_arrangements.push_back(
      from_list(10, '{127, 127, 127, 127, 127, 127, 127, 127, 127, 127}));
    pending_arrangements.push_back(
      from_list(10, '{-128, 127, -128, 127, -128, 127, -128, 127, -128, 127}));
    pending_arrangements.push_back(random_arrangement(11, 3));
    pending_arrangements.push_back(
      from_list(15, '{9, 8, 7, 6, 5, 4, 3, 2, 1, 0}));
    pending_arrangements.push_back(
      from_list(5, '{1, 5, 4, 3, 2, 127, -128, 127, -128, 0}));
    pending_arrangements.push_back(
      from_list(4, '{4, 3, 2, 1, -128, 127, -128, 127, 55, -55}));
    pending_arrangements.push_back(
      from_list(10, '{0, 0, 1, 1, 2, 2, 3, 3, 4, 4}));
    pending_arrangements.push_back(
      from_list(9, '{-1, -2, -3, -4, -5, -6, -7, -9, -8, 100}));
    // Drain the pipe once between directed and random beats
    a = random_arrangement(6, 255);
    a.hold_for_drain = 1'b1;
    pending_arrangements.push_back(a);

    while (pending_arrangements.size() < 22 + N_RANDOM) begin
      pick = $urandom_range(0, 9);
      if (pick <= 3) begin
        // Walk successive permutations of one multiset, wrapping included
        a = random_arrangement(($urandom_range(0, 4) == 0) ? $urandom_range(2, 10)
                                                           : $urandom_range(2, 5),
                               ($urandom_range(0, 1) == 0) ? 2 : 255);
        len = $urandom_range(4, 20);
        for (int i = 0; i < len; i++) begin
          pending_arrangements.push_back(a);
          s = next_arrangement(a);
          a.elem = s.elem;
        end
      end else if (pick <= 5) begin
        // Non-increasing run: a last permutation
        a = random_arrangement($urandom_range(0, 15), 255);
        v = $urandom_range(0, 255) - 128;
        for (int k = 0; k < N_ELEMS; k++) begin
          if (k < a.count) begin
            a.elem[k] = elem_t'(v);
            v = v - $urandom_range(0, 30);
            if (v < -128) v = -128;
          end
        end
        pending_arrangements.push_back(a);
      end else begin
        pending_arrangements.push_back(
          random_arrangement($urandom_range(0, 15),
                             ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 255));
      end
      if ($urandom_range(0, 199) == 0)
        pending_arrangements[pending_arrangements.size()-1].hold_for_drain = 1'b1;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (pending_arrangements.size() != 0 || s_axis_tvalid || successors_due.size() != 0);
    repeat (8) @(posedge clk_i);

    if (mismatch_cnt == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // Input driver: bursts of beats with random gaps in between
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) successors_due.push_back(next_arrangement(on_bus));
      if (!s_axis_tvalid || s_axis_tready) begin
        send_now = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_arrangements.size() != 0 &&
                     !(pending_arrangements[0].hold_for_drain &&
                       successors_due.size() != 0)) begin
          on_bus = pending_arrangements.pop_front();
          send_now = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap_left = $urandom_range(1, 10);
          end
        end
        if (send_now) begin
          beat_bits = '0;
          beat_bits[CNT_W-1:0] = on_bus.count;
          for (int k = 0; k < N_ELEMS; k++) beat_bits[CNT_W + k*ELEM_W +: ELEM_W] = on_bus.elem[k];
          s_axis_tdata <= beat_bits;
        end
        s_axis_tvalid <= send_now;
      end
    end
  end

  // Output back-pressure: a random stall pattern, picked anew whenever its mode counter runs out
  always @(posedge clk_i) begin
    if (mode_cycles == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_cycles = $urandom_range(20, 100);
    end else begin
      mode_cycles--;
    end
    case (stall_mode)
      0: ready_now = 1'b1;
      1: ready_now = ($urandom_range(0, 1) == 0);
      2: ready_now = ($urandom_range(0, 3) == 0);
      default: ready_now = (mode_cycles % 3 != 0);
    endcase
    m_axis_tready <= ready_now;
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (successors_due.size() == 0) begin
        $display("%0t: result beat with no arrangement pending, tuser %b tdata %h",
                 $time, m_axis_tuser, m_axis_tdata);
        mismatch_cnt++;
      end else begin
        exp_succ = successors_due.pop_front();
        if (m_axis_tuser !== exp_succ.advanced) begin
          $display("%0t: advanced mismatch, expected %b, actual %b",
                   $time, exp_succ.advanced, m_axis_tuser);
          mismatch_cnt++;
        end
        for (int k = 0; k < N_ELEMS; k++) begin
          got_elem = m_axis_tdata[k*ELEM_W +: ELEM_W];
          if (got_elem !== exp_succ.elem[k]) begin
            $display("%0t: elem_out_%0d mismatch, expected %0d, actual %0d",
                     $time, k, exp_succ.elem[k], got_elem);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any beat on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
